@@ rtl/acet_pkg.sv @@
// Shared types and constants for the AABB contact event tracker.
`timescale 1ns / 1ps
`default_nettype none
package acet_pkg;

  localparam int NUM_TYPES_DEF     = 8;
  localparam int MAX_COLLIDERS_DEF = 64;
  localparam int COORD_WIDTH_DEF   = 16;

  localparam int TYPE_PAIR_W = 6;
  localparam int ID_W        = 6;
  localparam int ID_EXT_W    = 8;   // holds any id below the largest collider count
  localparam int CFG_W       = 64;
  localparam int EVT_W       = 2;

  typedef enum logic [EVT_W-1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_event_t;

  // Classification of one candidate pair, passed from front to back.
  typedef struct packed {
    logic pair_ok;   // enabled types, distinct in-range ids
    logic ov;        // boxes overlap
    logic dead;
  } pair_class_t;

  // Back-end status seen by the front.
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage
`default_nettype wire

@@ rtl/aabb_contact_event_tracker_core.sv @@
// Top level of the AABB contact event tracker.
// Each candidate collider pair yields one result: enter, stay, exit or none, plus the
// overlap bit. The front end tests enables, ids and box sums in one register stage,
// then the magnitude compare lands in a two-entry queue that feeds the back end. The
// back end registers the bit it reads from the one-bit pair contact table and writes
// the table on enter or exit when the result is taken; it takes no new pair until the
// last one's result is registered. A pair passes the stage-1 register, the queue, the
// lookup register and the result register. After reset the back end clears all
// 2**(2*ceil(log2(MAX_COLLIDERS))) table entries (4096 at 64 colliders), one entry a
// cycle, and takes no pairs meanwhile; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
module aabb_contact_event_tracker_core #(
  parameter int NUM_TYPES     = acet_pkg::NUM_TYPES_DEF,
  parameter int MAX_COLLIDERS = acet_pkg::MAX_COLLIDERS_DEF,
  parameter int COORD_WIDTH   = acet_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [acet_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [acet_pkg::TYPE_PAIR_W-1:0]  type_pair,
  input  wire logic [acet_pkg::ID_W-1:0]         left_id,
  input  wire logic [acet_pkg::ID_W-1:0]         right_id,
  input  wire logic signed [COORD_WIDTH-1:0]     left_x,
  input  wire logic signed [COORD_WIDTH-1:0]     left_y,
  input  wire logic [COORD_WIDTH-1:0]            left_w,
  input  wire logic [COORD_WIDTH-1:0]            left_h,
  input  wire logic signed [COORD_WIDTH-1:0]     right_x,
  input  wire logic signed [COORD_WIDTH-1:0]     right_y,
  input  wire logic [COORD_WIDTH-1:0]            right_w,
  input  wire logic [COORD_WIDTH-1:0]            right_h,
  input  wire logic                              either_dead,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [acet_pkg::EVT_W-1:0]             contact_event,
  output logic                                   boxes_overlap
);
  import acet_pkg::*;

  localparam int IDX_W  = $clog2(MAX_COLLIDERS);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int QW     = ADDR_W + $bits(pair_class_t);

  back_status_t      back_status;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  pair_class_t       push_cls;
  logic [ADDR_W-1:0] push_idx;
  pair_class_t       pop_cls;
  logic [ADDR_W-1:0] pop_idx;

  acet_front #(
    .NUM_TYPES     (NUM_TYPES),
    .MAX_COLLIDERS (MAX_COLLIDERS),
    .COORD_WIDTH   (COORD_WIDTH),
    .IDX_W         (IDX_W),
    .ADDR_W        (ADDR_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .type_pair   (type_pair),
    .left_id     (left_id),
    .right_id    (right_id),
    .left_x      (left_x),
    .left_y      (left_y),
    .left_w      (left_w),
    .left_h      (left_h),
    .right_x     (right_x),
    .right_y     (right_y),
    .right_w     (right_w),
    .right_h     (right_h),
    .either_dead (either_dead),
    .back_status (back_status),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cls       (push_cls),
    .q_idx       (push_idx)
  );

  acet_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_cls, push_idx}),
    .pop       (q_pop),
    .pop_data  ({pop_cls, pop_idx}),
    .full      (q_full),
    .empty     (q_empty)
  );

  acet_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_cls         (pop_cls),
    .q_idx         (pop_idx),
    .q_pop         (q_pop),
    .back_status   (back_status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .contact_event (contact_event),
    .boxes_overlap (boxes_overlap)
  );
endmodule
`default_nettype wire

@@ rtl/acet_queue.sv @@
// Two-entry queue between the classifier front and the table back end.
`timescale 1ns / 1ps
`default_nettype none
module acet_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              full,
  output logic              empty
);
  import acet_pkg::*;

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("queue count did not follow push");
endmodule
`default_nettype wire

@@ rtl/acet_front.sv @@
// Front end: takes candidate pairs, checks enables and ids, tests box overlap.
`timescale 1ns / 1ps
`default_nettype none
module acet_front #(
  parameter int NUM_TYPES     = acet_pkg::NUM_TYPES_DEF,
  parameter int MAX_COLLIDERS = acet_pkg::MAX_COLLIDERS_DEF,
  parameter int COORD_WIDTH   = acet_pkg::COORD_WIDTH_DEF,
  parameter int IDX_W         = $clog2(MAX_COLLIDERS),
  parameter int ADDR_W        = 2 * IDX_W
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [acet_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [acet_pkg::TYPE_PAIR_W-1:0]  type_pair,
  input  wire logic [acet_pkg::ID_W-1:0]         left_id,
  input  wire logic [acet_pkg::ID_W-1:0]         right_id,
  input  wire logic signed [COORD_WIDTH-1:0]     left_x,
  input  wire logic signed [COORD_WIDTH-1:0]     left_y,
  input  wire logic [COORD_WIDTH-1:0]            left_w,
  input  wire logic [COORD_WIDTH-1:0]            left_h,
  input  wire logic signed [COORD_WIDTH-1:0]     right_x,
  input  wire logic signed [COORD_WIDTH-1:0]     right_y,
  input  wire logic [COORD_WIDTH-1:0]            right_w,
  input  wire logic [COORD_WIDTH-1:0]            right_h,
  input  wire logic                              either_dead,
  input  wire acet_pkg::back_status_t            back_status,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output acet_pkg::pair_class_t                  q_cls,
  output logic [ADDR_W-1:0]                      q_idx
);
  import acet_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic [CFG_W-1:0] type_pair_enable;

  // stage 1: differences and size sums
  logic                s1_valid;
  logic signed [CW:0]  s1_dx;
  logic signed [CW:0]  s1_dy;
  logic [CW:0]         s1_ws;
  logic [CW:0]         s1_hs;
  logic                s1_pair_ok;
  logic                s1_dead;
  logic [ADDR_W-1:0]   s1_idx;

  logic [2:0]          row;
  logic [2:0]          col;
  logic                types_ok;
  logic                ids_ok;
  logic [ID_EXT_W-1:0] lid_ext;
  logic [ID_EXT_W-1:0] rid_ext;
  logic                s1_load;

  logic [CW:0]         adx;
  logic [CW:0]         ady;

  assign cfg_ready = 1'b1;

  assign row      = type_pair[5:3];
  assign col      = type_pair[2:0];
  assign types_ok = (32'(row) < NUM_TYPES) && (32'(col) < NUM_TYPES)
                    && type_pair_enable[type_pair];
  assign ids_ok   = (left_id != right_id) && (32'(left_id) < MAX_COLLIDERS)
                    && (32'(right_id) < MAX_COLLIDERS);
  assign lid_ext  = ID_EXT_W'(left_id);
  assign rid_ext  = ID_EXT_W'(right_id);

  assign in_ready = !back_status.clearing && (!s1_valid || !q_full);
  assign s1_load  = in_valid && in_ready;
  assign q_push   = s1_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_pair_enable <= '0;
    end else if (cfg_valid && cfg_ready) begin
      type_pair_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_dx      <= {right_x[CW-1], right_x} - {left_x[CW-1], left_x};
      s1_dy      <= {right_y[CW-1], right_y} - {left_y[CW-1], left_y};
      s1_ws      <= {1'b0, left_w} + {1'b0, right_w};
      s1_hs      <= {1'b0, left_h} + {1'b0, right_h};
      s1_pair_ok <= types_ok && ids_ok;
      s1_dead    <= either_dead;
      s1_idx     <= {lid_ext[IDX_W-1:0], rid_ext[IDX_W-1:0]};
    end
  end

  // stage 2: magnitude and compare, 2|d| < sum
  assign adx = s1_dx[CW] ? (~s1_dx + 1'b1) : s1_dx;
  assign ady = s1_dy[CW] ? (~s1_dy + 1'b1) : s1_dy;

  always_comb begin
    q_cls.pair_ok = s1_pair_ok;
    q_cls.ov      = ({adx, 1'b0} < {1'b0, s1_ws}) && ({ady, 1'b0} < {1'b0, s1_hs});
    q_cls.dead    = s1_dead;
    q_idx         = s1_idx;
  end
endmodule
`default_nettype wire

@@ rtl/acet_back.sv @@
// Back end: pair contact table, event decision and result register.
`timescale 1ns / 1ps
`default_nettype none
module acet_back #(
  parameter int ADDR_W = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      q_empty,
  input  wire acet_pkg::pair_class_t     q_cls,
  input  wire logic [ADDR_W-1:0]         q_idx,
  output logic                           q_pop,
  output acet_pkg::back_status_t         back_status,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [acet_pkg::EVT_W-1:0]     contact_event,
  output logic                           boxes_overlap
);
  import acet_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK} state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_cnt;
  pair_class_t       cur_cls;
  logic [ADDR_W-1:0] cur_idx;

  logic              pair_contact [2**ADDR_W];
  logic              rd_bit;

  logic              take;
  logic              upd;
  contact_event_t    ev;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_wdata;

  assign q_pop                = (state == S_IDLE) && !q_empty;
  assign back_status.clearing = (state == S_CLEAR);
  assign take                 = (state == S_LOOK) && (!out_valid || out_ready);

  always_comb begin
    ev = EV_NONE;
    if (cur_cls.pair_ok) begin
      if (cur_cls.ov) begin
        if (rd_bit) ev = cur_cls.dead ? EV_EXIT : EV_STAY;
        else if (!cur_cls.dead) ev = EV_ENTER;
      end else if (rd_bit) begin
        ev = EV_EXIT;
      end
    end
    upd = (ev == EV_ENTER) || (ev == EV_EXIT);
  end

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = 1'b0;
    end else begin
      mem_we    = take && upd;
      mem_waddr = cur_idx;
      mem_wdata = (ev == EV_ENTER);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pair_contact[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      rd_bit <= pair_contact[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == {ADDR_W{1'b1}}) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) state <= S_LOOK;
        end
        S_LOOK: begin
          if (take) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (q_pop) begin
      cur_cls <= q_cls;
      cur_idx <= q_idx;
    end
    if (take) begin
      contact_event <= ev;
      boxes_overlap <= cur_cls.pair_ok && cur_cls.ov;
    end
  end

  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst)
      back_status.clearing |-> !q_pop)
    else $error("pair taken during table clear");
  a_enter_needs_overlap: assert property (@(posedge clk) disable iff (rst)
      (take && (ev == EV_ENTER || ev == EV_STAY)) |=> boxes_overlap)
    else $error("enter or stay without overlap");
  a_rejected_is_none: assert property (@(posedge clk) disable iff (rst)
      (take && !cur_cls.pair_ok) |=> (contact_event == EV_NONE && !boxes_overlap))
    else $error("rejected pair produced an event");
  a_result_waits: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |=> (state != S_IDLE || $stable(contact_event)))
    else $error("pending result overwritten");
endmodule
`default_nettype wire
